/* rtl/core/ltf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltf_pkg
// Shared types, sizes and the Laws kernel table for the 5x5 texture filter.
// ----------------------------------------------------------------------------
package ltf_pkg;

   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 4096;
   localparam int MIN_SIZE    = 5;
   localparam int TAPS        = 5;
   localparam int STORE_ROWS  = 4;
   localparam int LANE_W      = $clog2(STORE_ROWS);
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int MAX_RESULTS = 3;
   localparam int RSP_DEPTH   = 8;
   localparam int RESP_W      = 21;
   localparam int COL_W       = 19;
   localparam int SUM_W       = 26;

   localparam logic [2:0] KSEL_L5 = 3'd0;
   localparam logic [2:0] KSEL_E5 = 3'd1;
   localparam logic [2:0] KSEL_S5 = 3'd2;
   localparam logic [2:0] KSEL_W5 = 3'd3;
   localparam logic [2:0] KSEL_R5 = 3'd4;

   localparam logic [1:0] RES_NONE  = 2'd0;
   localparam logic [1:0] RES_ONE   = 2'd1;
   localparam logic [1:0] RES_THREE = 2'd3;

   typedef logic [7:0] pixel_type;
   typedef pixel_type [TAPS-1:0] column_type;
   typedef column_type [TAPS-1:0] window_type;
   typedef logic signed [3:0] coef_type;
   typedef coef_type [TAPS-1:0] kernel_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] count;
      logic       last_row;
   } res_ctl_type;

   typedef struct packed {
      logic signed [RESP_W-1:0] response;
      logic                     end_of_run;
      logic                     end_of_frame;
   } result_type;

   typedef struct packed {
      logic [1:0]                       count;
      result_type [MAX_RESULTS-1:0] item;
   } push_type;

   function automatic kernel_type laws_kernel(input logic [2:0] sel);
      kernel_type k;
      k = '0;
      unique case (sel)
         KSEL_L5: begin
            k[0] = 4'sd1;  k[1] = 4'sd4;  k[2] = 4'sd6;  k[3] = 4'sd4;  k[4] = 4'sd1;
         end
         KSEL_E5: begin
            k[0] = -4'sd1; k[1] = -4'sd2; k[2] = 4'sd0;  k[3] = 4'sd2;  k[4] = 4'sd1;
         end
         KSEL_S5: begin
            k[0] = -4'sd1; k[1] = 4'sd0;  k[2] = 4'sd2;  k[3] = 4'sd0;  k[4] = -4'sd1;
         end
         KSEL_W5: begin
            k[0] = -4'sd1; k[1] = 4'sd2;  k[2] = 4'sd0;  k[3] = -4'sd2; k[4] = 4'sd1;
         end
         KSEL_R5: begin
            k[0] = 4'sd1;  k[1] = -4'sd4; k[2] = 4'sd6;  k[3] = -4'sd4; k[4] = 4'sd1;
         end
         default: begin
            k = '0;
         end
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/ltf_mask_sum.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltf_mask_sum
// Separable mask arithmetic: registered column sums, then one horizontal sum
// per item, or a set of three at a row end, handed to the result queue.
// ----------------------------------------------------------------------------
module ltf_mask_sum import ltf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  res_ctl_type ctl_in,
   input  window_type  window_in,
   input  logic [2:0]  v_sel,
   input  logic [2:0]  h_sel,
   input  logic [11:0] mean_level,
   output push_type    push_out
);

   kernel_type                kv;
   kernel_type                kh;
   logic signed [6:0]         ksum;
   logic signed [COL_W-1:0]   mean_term;
   logic signed [COL_W-1:0]   psum [TAPS];
   logic signed [COL_W-1:0]   col_sum [TAPS];
   logic signed [COL_W-1:0]   col_ff [TAPS];
   res_ctl_type               ctl_ff;
   logic signed [SUM_W-1:0]   resp [MAX_RESULTS];

   // vertical weighting of each column slot, mean folded in once per column
   always_comb begin
      kv = laws_kernel(v_sel);
      ksum = '0;
      for (int r = 0; r < TAPS; r++) begin
         ksum = ksum + 7'(kv[r]);
      end
      mean_term = COL_W'($signed({1'b0, mean_level})) * COL_W'(ksum);
      for (int c = 0; c < TAPS; c++) begin
         psum[c] = '0;
         for (int r = 0; r < TAPS; r++) begin
            psum[c] = psum[c] + COL_W'(kv[r]) * COL_W'($signed({1'b0, window_in[c][r]}));
         end
         col_sum[c] = (psum[c] <<< 4) - mean_term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      for (int c = 0; c < TAPS; c++) begin
         col_ff[c] <= col_sum[c];
      end
   end

   // result j sees the window shifted j times with the last column replicated
   always_comb begin
      kh = laws_kernel(h_sel);
      for (int j = 0; j < MAX_RESULTS; j++) begin
         resp[j] = '0;
         for (int c = 0; c < TAPS; c++) begin
            resp[j] = resp[j] + SUM_W'(kh[c]) *
                      SUM_W'(col_ff[(c + j > TAPS - 1) ? TAPS - 1 : c + j]);
         end
      end
      push_out.count = ctl_ff.valid ? ctl_ff.count : RES_NONE;
      push_out.item[0].response     = resp[0][RESP_W-1:0];
      push_out.item[0].end_of_run   = (ctl_ff.count == RES_ONE);
      push_out.item[0].end_of_frame = 1'b0;
      push_out.item[1].response     = resp[1][RESP_W-1:0];
      push_out.item[1].end_of_run   = 1'b0;
      push_out.item[1].end_of_frame = 1'b0;
      push_out.item[2].response     = resp[2][RESP_W-1:0];
      push_out.item[2].end_of_run   = 1'b1;
      push_out.item[2].end_of_frame = ctl_ff.last_row;
   end

endmodule
`default_nettype wire

/* rtl/core/ltf_rsp_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltf_rsp_fifo
// Result queue: takes up to three results per cycle, hands them out one at a time.
// ----------------------------------------------------------------------------
module ltf_rsp_fifo import ltf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push_in,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_item
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   result_type       entry_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_in.count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_in.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (k < int'(push_in.count)) begin
            entry_ff[wr_ptr_ff + PTR_W'(k)] <= push_in.item[k];
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/core/laws_texture_filter_5x5.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// laws_texture_filter_5x5
// Streaming 5x5 Laws texture mask over a raster of 8-bit gray pixels.
// ----------------------------------------------------------------------------
// Feed pixels of one frame in raster order on req_ (tuser 0), then flush items
// (tuser 1), one per pixel of the two rows past the frame, to drain the last
// rows. Each accepted item gives zero, one or three results on rsp_; tlast
// marks the last result of an item, tuser marks the response of the frame's
// last pixel. One item is taken every cycle while req_tready is high. The rate
// is set by the one row-store port, read and written once per item, and the
// queue drains one result per cycle while rsp_tready is high: req_tready drops
// while more than five results are queued or in flight, so a stalled receiver
// backs the input up after at most eight results. Reset clears position, queue
// and pipeline and loads the register defaults (512x512, L5 x L5, mean 0); the
// row store is not cleared. The user must write registers on csr_ only while no
// item is in flight; the block does not enforce it. csr_ready is always high.
// ----------------------------------------------------------------------------
module laws_texture_filter_5x5 import ltf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic [0:0]  req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] filter_response, [23:21] zero
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,   // [0] end_of_frame
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_VERT_KSEL    = 3'd2;
   localparam logic [2:0] CSR_HORZ_KSEL    = 3'd3;
   localparam logic [2:0] CSR_MEAN_LEVEL   = 3'd4;
   localparam logic       MODE_FLUSH       = 1'b1;
   localparam int         PEND_W           = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic                          valid;
      pixel_type                     pixel;
      logic                          col_start;
      logic [TAPS-1:0]               use_px;
      logic [TAPS-1:0][LANE_W-1:0]   lane;
      logic [1:0]                    count;
      logic                          last_row;
   } stage1_type;

   logic [9:0]   width_ff,  width_in;
   logic [12:0]  height_ff, height_in;
   logic [2:0]   vsel_ff;
   logic [2:0]   hsel_ff;
   logic [11:0]  mean_ff;

   logic [12:0]  row_ff, row_in;
   logic [9:0]   col_ff, col_in;
   logic [PEND_W-1:0] pending_ff, pending_in;

   logic [STORE_ROWS*8-1:0] row_mem [MAX_WIDTH];
   logic [STORE_ROWS*8-1:0] store_rd_ff;

   stage1_type   s1_ff, s1_in;
   window_type   window_ff;
   column_type   column;
   res_ctl_type  mask_ctl_ff;
   push_type     push;
   result_type   head;

   logic [13:0]  height_p2;
   logic [12:0]  height_m1;
   logic [9:0]   width_m1;
   logic [12:0]  row_n;
   logic [9:0]   col_n;
   logic [9:0]   ic;
   logic         drop;
   logic         accept;
   logic         keep;
   logic         emit;
   logic         row_end;
   logic [1:0]   n_results;
   logic [13:0]  row_inc;
   logic signed [14:0] rk [TAPS];
   logic [12:0]  rcl [TAPS];
   logic         rsp_take;

   assign csr_ready = 1'b1;

   // register writes, width and height held already clamped
   always_comb begin
      width_in = csr_wdata[9:0];
      if (width_in < 10'(MIN_SIZE)) begin
         width_in = 10'(MIN_SIZE);
      end else if (width_in > 10'(MAX_WIDTH)) begin
         width_in = 10'(MAX_WIDTH);
      end
      height_in = csr_wdata;
      if (height_in < 13'(MIN_SIZE)) begin
         height_in = 13'(MIN_SIZE);
      end else if (height_in > 13'(MAX_HEIGHT)) begin
         height_in = 13'(MAX_HEIGHT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 10'(MAX_WIDTH);
         height_ff <= 13'd512;
         vsel_ff   <= KSEL_L5;
         hsel_ff   <= KSEL_L5;
         mean_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= width_in;
            CSR_FRAME_HEIGHT: height_ff <= height_in;
            CSR_VERT_KSEL:    vsel_ff   <= csr_wdata[2:0];
            CSR_HORZ_KSEL:    hsel_ff   <= csr_wdata[2:0];
            CSR_MEAN_LEVEL:   mean_ff   <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // item position, drop rules and row-store lanes for the five window rows
   always_comb begin
      height_p2 = {1'b0, height_ff} + 14'd2;
      height_m1 = height_ff - 13'd1;
      width_m1  = width_ff - 10'd1;
      if ({1'b0, row_ff} >= height_p2) begin
         row_n = '0;
         col_n = '0;
      end else begin
         row_n = row_ff;
         col_n = col_ff;
      end
      if (req_tuser[0] == MODE_FLUSH) begin
         drop = (row_n < height_ff);
      end else begin
         drop = (row_n >= height_ff);
      end
      ic      = (col_n > width_m1) ? width_m1 : col_n;
      row_end = (ic == width_m1);
      emit    = (row_n >= 13'd2) && (ic >= 10'd2);
      if (!emit) begin
         n_results = RES_NONE;
      end else if (row_end) begin
         n_results = RES_THREE;
      end else begin
         n_results = RES_ONE;
      end
      for (int k = 0; k < TAPS; k++) begin
         rk[k] = $signed({2'b00, row_n}) - 15'sd4 + $signed(15'(k));
         if (rk[k] < 15'sd0) begin
            rcl[k] = '0;
         end else if (rk[k] > $signed({2'b00, height_m1})) begin
            rcl[k] = height_m1;
         end else begin
            rcl[k] = rk[k][12:0];
         end
      end
      accept = req_tvalid && req_tready;
      keep   = accept && !drop;

      s1_in.valid     = keep;
      s1_in.pixel     = req_tdata;
      s1_in.col_start = (ic == '0);
      for (int k = 0; k < TAPS; k++) begin
         s1_in.use_px[k] = (rcl[k] == row_n);
         s1_in.lane[k]   = rcl[k][LANE_W-1:0];
      end
      s1_in.count    = n_results;
      s1_in.last_row = ({1'b0, row_n} == {1'b0, height_ff} + 14'd1);

      row_inc = {1'b0, row_n} + 14'd1;
      if (!accept) begin
         row_in = row_ff;
         col_in = col_ff;
      end else if (drop) begin
         row_in = row_n;
         col_in = col_n;
      end else if (!row_end) begin
         row_in = row_n;
         col_in = ic + 10'd1;
      end else if (row_inc >= height_p2) begin
         row_in = '0;
         col_in = '0;
      end else begin
         row_in = row_inc[12:0];
         col_in = '0;
      end
   end

   assign req_tready = (pending_ff <= PEND_W'(RSP_DEPTH - MAX_RESULTS));
   assign rsp_take   = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff + (keep ? PEND_W'(n_results) : '0) - PEND_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         pending_ff <= '0;
         s1_ff      <= '0;
      end else begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         pending_ff <= pending_in;
         s1_ff      <= s1_in;
      end
   end

   // row store: one word per column, one byte lane per ring row; read-first
   always_ff @(posedge clock) begin
      if (keep) begin
         store_rd_ff <= row_mem[ADDR_W'(ic)];
         if (req_tuser[0] != MODE_FLUSH) begin
            row_mem[ADDR_W'(ic)][row_n[LANE_W-1:0]*8 +: 8] <= req_tdata;
         end
      end
   end

   // assemble the new column and advance the window, or fill it at a row start
   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         column[k] = s1_ff.use_px[k] ? s1_ff.pixel : store_rd_ff[s1_ff.lane[k]*8 +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= '0;
         mask_ctl_ff <= '0;
      end else begin
         if (s1_ff.valid) begin
            if (s1_ff.col_start) begin
               for (int c = 0; c < TAPS; c++) begin
                  window_ff[c] <= column;
               end
            end else begin
               for (int c = 0; c < TAPS - 1; c++) begin
                  window_ff[c] <= window_ff[c + 1];
               end
               window_ff[TAPS-1] <= column;
            end
         end
         mask_ctl_ff.valid    <= s1_ff.valid && (s1_ff.count != RES_NONE);
         mask_ctl_ff.count    <= s1_ff.count;
         mask_ctl_ff.last_row <= s1_ff.last_row;
      end
   end

   ltf_mask_sum u_mask_sum (
      .clock      (clock),
      .reset      (reset),
      .ctl_in     (mask_ctl_ff),
      .window_in  (window_ff),
      .v_sel      (vsel_ff),
      .h_sel      (hsel_ff),
      .mean_level (mean_ff),
      .push_out   (push)
   );

   ltf_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = {3'b000, head.response};
   assign rsp_tlast = head.end_of_run;
   assign rsp_tuser = head.end_of_frame;

`ifndef SYNTHESIS
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PEND_W'(RSP_DEPTH))
      else $error("result credit count above queue depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != '0)
      else $error("result shown with no credit held");

   a_eof_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame end without end of run");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.count != RES_NONE |-> pending_ff >= PEND_W'(push.count))
      else $error("queue push exceeds reserved credit");
`endif

endmodule
`default_nettype wire

/* dv/laws_texture_filter_5x5_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laws_texture_filter_5x5_tb
// Self-checking bench for the streaming 5x5 Laws texture filter. A directed
// table of register writes and frames runs first, then random frames with
// random geometry, kernels and mean. Every result is checked against an
// in-bench model or a fixed response, with random stalls on both streams.
// ----------------------------------------------------------------------------
module laws_texture_filter_5x5_tb;
   import ltf_pkg::*;

   localparam int     CLK_HALF     = 2;
   localparam int     RESET_CYCLES = 8;
   localparam int     SETTLE       = 8;
   localparam int     LONG_HOLD    = 300;
   localparam int     RANDOM_ITEMS = 500;
   localparam int     MAX_REPORTS  = 10;
   localparam longint LIMIT_NS     = 5_000_000;
   localparam int     ANY_PIXEL    = -1;
   localparam int     FULL_SCALE   = 1044480;
   localparam int     LOW_SCALE    = -1048320;

   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_VERT_SEL     = 3'd2;
   localparam logic [2:0] REG_HORIZ_SEL    = 3'd3;
   localparam logic [2:0] REG_MEAN_LEVEL   = 3'd4;
   localparam logic [2:0] REG_UNUSED       = 3'd7;

   localparam logic [2:0] KSEL_ZERO_LO = 3'd5;
   localparam logic [2:0] KSEL_ZERO_HI = 3'd7;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   typedef enum logic {STEP_REG, STEP_ITEM} step_kind_e;

   typedef struct {
      step_kind_e  kind;
      logic [2:0]  idx;
      logic [12:0] value;
      logic        mode;
      int          pixel;
      int          reps;
      logic        typed;
      int          resp;
   } step_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] pixel
   logic [0:0]  req_tuser;   // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [20:0] filter_response, [23:21] zero
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;   // [0] end_of_frame
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [12:0] csr_wdata;

   step_type   plan [$];
   result_type pending [$];
   result_type oldest;
   int         errors = 0;
   int         gap_pct = 0;
   int         stall_pct = 0;
   logic       hold_request = 1'b0;
   logic       typed_en = 1'b0;
   int         typed_resp = 0;

   bit [7:0]                  line_store [STORE_ROWS * MAX_WIDTH];
   bit [TAPS-1:0][TAPS-1:0][7:0] window = '0;
   int unsigned at_col = 0;
   int unsigned at_row = 0;
   int unsigned flushes_taken = 0;
   int unsigned shadow_width = 512;
   int unsigned shadow_height = 512;
   logic [2:0]  shadow_vsel = KSEL_L5;
   logic [2:0]  shadow_hsel = KSEL_L5;
   int unsigned shadow_mean = 0;

   laws_texture_filter_5x5 i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("laws_texture_filter_5x5_tb: done, errors");
      $finish;
   end

   function automatic int laws_weight(input logic [2:0] sel, input int k);
      int taps [TAPS];
      case (sel)
         KSEL_L5: taps = '{ 1,  4, 6,  4,  1};
         KSEL_E5: taps = '{-1, -2, 0,  2,  1};
         KSEL_S5: taps = '{-1,  0, 2,  0, -1};
         KSEL_W5: taps = '{-1,  2, 0, -2,  1};
         KSEL_R5: taps = '{ 1, -4, 6, -4,  1};
         default: taps = '{ 0,  0, 0,  0,  0};
      endcase
      return taps[k];
   endfunction

   function automatic int window_sum();
      int total;
      int c;
      int r;
      total = 0;
      for (c = 0; c < TAPS; c++)
         for (r = 0; r < TAPS; r++)
            total += laws_weight(shadow_vsel, r) * laws_weight(shadow_hsel, c)
                     * (int'(window[c][r]) * 16 - int'(shadow_mean));
      return total;
   endfunction

   function automatic void slide_window(input bit [TAPS-1:0][7:0] col);
      int c;
      for (c = 0; c < TAPS - 1; c++)
         window[c] = window[c + 1];
      window[TAPS-1] = col;
   endfunction

   function automatic void emit_result(input logic eof, input logic last);
      result_type res;
      int total;
      total = window_sum();
      res.response     = typed_en ? typed_resp[RESP_W-1:0] : total[RESP_W-1:0];
      res.end_of_run   = last;
      res.end_of_frame = eof;
      pending.push_back(res);
   endfunction

   function automatic void apply_reg(input logic [2:0] idx, input logic [12:0] value);
      case (idx)
         REG_FRAME_WIDTH:  shadow_width = value[9:0];
         REG_FRAME_HEIGHT: shadow_height = value;
         REG_VERT_SEL:     shadow_vsel = value[2:0];
         REG_HORIZ_SEL:    shadow_hsel = value[2:0];
         REG_MEAN_LEVEL:   shadow_mean = value[11:0];
         default: ;
      endcase
   endfunction

   function automatic void predict_item(input logic mode_bit, input bit [7:0] px);
      int unsigned w;
      int unsigned h;
      int unsigned ic;
      int unsigned ir;
      int r;
      int k;
      logic last_row;
      bit [TAPS-1:0][7:0] col;
      w = shadow_width;
      if (w < MIN_SIZE) w = MIN_SIZE;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = shadow_height;
      if (h < MIN_SIZE) h = MIN_SIZE;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      if (at_row >= h + 2) begin
         at_row = 0;
         at_col = 0;
         flushes_taken = 0;
      end
      if (mode_bit == MODE_PIXEL && at_row >= h) return;
      if (mode_bit == MODE_FLUSH && at_row < h) return;
      ic = (at_col > w - 1) ? w - 1 : at_col;
      ir = at_row;
      for (k = 0; k < TAPS; k++) begin
         r = int'(ir) - 4 + k;
         if (r < 0) r = 0;
         if (r > int'(h) - 1) r = int'(h) - 1;
         col[k] = (r == int'(ir)) ? px : line_store[(r % STORE_ROWS) * MAX_WIDTH + ic];
      end
      if (ic == 0) begin
         for (k = 0; k < TAPS; k++)
            window[k] = col;
      end else begin
         slide_window(col);
      end
      if (mode_bit == MODE_PIXEL)
         line_store[(ir % STORE_ROWS) * MAX_WIDTH + ic] = px;
      if (ir >= 2) begin
         last_row = (ir - 2 == h - 1);
         if (ic >= 2)
            emit_result(last_row && (ic - 2 == w - 1), ic != w - 1);
         if (ic == w - 1) begin
            slide_window(window[TAPS-1]);
            emit_result(1'b0, 1'b0);
            slide_window(window[TAPS-1]);
            emit_result(last_row, 1'b1);
         end
      end
      if (mode_bit == MODE_FLUSH)
         flushes_taken = (flushes_taken + 1) % 2048;
      if (ic + 1 >= w) begin
         at_col = 0;
         at_row = ir + 1;
      end else begin
         at_col = ic + 1;
      end
      if (at_row >= h + 2) begin
         at_row = 0;
         at_col = 0;
         flushes_taken = 0;
      end
   endfunction

   function automatic void flag_mismatch(input string msg);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t: mismatch: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            apply_reg(csr_index, csr_wdata);
         if (req_tvalid && req_tready)
            predict_item(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (pending.size() == 0) begin
               flag_mismatch($sformatf("unexpected result tdata=%h tlast=%b tuser=%b",
                                       rsp_tdata, rsp_tlast, rsp_tuser));
            end else begin
               oldest = pending.pop_front();
               if (rsp_tdata !== {{(24 - RESP_W){1'b0}}, oldest.response})
                  flag_mismatch($sformatf("response expected %0d actual %0d (tdata=%h)",
                                          oldest.response, $signed(rsp_tdata[RESP_W-1:0]),
                                          rsp_tdata));
               if (rsp_tlast !== oldest.end_of_run)
                  flag_mismatch($sformatf("end_of_run expected %b actual %b",
                                          oldest.end_of_run, rsp_tlast));
               if (rsp_tuser[0] !== oldest.end_of_frame)
                  flag_mismatch($sformatf("end_of_frame expected %b actual %b",
                                          oldest.end_of_frame, rsp_tuser[0]));
            end
         end
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   task automatic wait_drained();
      while (pending.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [12:0] value);
      wait_drained();
      csr_index = idx;
      csr_wdata = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_item(input logic mode_bit, input logic [7:0] px,
                            input logic typed, input int resp);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode_bit;
      req_tdata  = px;
      typed_en   = typed;
      typed_resp = resp;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   function automatic void plan_reg(input logic [2:0] idx, input logic [12:0] value);
      step_type s;
      s = '{STEP_REG, idx, value, MODE_PIXEL, 0, 0, 1'b0, 0};
      plan.push_back(s);
   endfunction

   function automatic void plan_items(input logic mode_bit, input int px, input int reps,
                                      input logic typed, input int resp);
      step_type s;
      s = '{STEP_ITEM, REG_UNUSED, 13'd0, mode_bit, px, reps, typed, resp};
      plan.push_back(s);
   endfunction

   initial begin
      int          i;
      int          n;
      int          phase;
      int          random_items;
      int unsigned w;
      int unsigned h;
      int unsigned row;
      int unsigned colno;
      logic [12:0] spare;
      logic [9:0]  wide;
      logic [2:0]  sel;
      logic [11:0] mean;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;

      // flat frames: borders replicate, so every response is full scale, then low scale with mean 4095
      plan_reg(REG_FRAME_WIDTH, 13'd5);
      plan_reg(REG_FRAME_HEIGHT, 13'd5);
      plan_reg(REG_VERT_SEL, {10'd0, KSEL_L5});
      plan_reg(REG_HORIZ_SEL, {10'd0, KSEL_L5});
      plan_reg(REG_MEAN_LEVEL, 13'd0);
      plan_items(MODE_PIXEL, 255, 12, 1'b1, FULL_SCALE);
      plan_items(MODE_FLUSH, 0, 1, 1'b0, 0);
      plan_items(MODE_PIXEL, 255, 13, 1'b1, FULL_SCALE);
      plan_items(MODE_FLUSH, 0, 4, 1'b1, FULL_SCALE);
      plan_items(MODE_PIXEL, 0, 1, 1'b0, 0);
      plan_items(MODE_FLUSH, 0, 6, 1'b1, FULL_SCALE);
      plan_reg(REG_MEAN_LEVEL, 13'd4095);
      plan_items(MODE_PIXEL, 0, 25, 1'b1, LOW_SCALE);
      plan_items(MODE_FLUSH, 0, 10, 1'b1, LOW_SCALE);
      // kernel selects with no table entry weigh everything by zero
      plan_reg(REG_VERT_SEL, {10'd0, KSEL_ZERO_HI});
      plan_reg(REG_HORIZ_SEL, {10'd0, KSEL_ZERO_LO});
      plan_items(MODE_PIXEL, ANY_PIXEL, 25, 1'b1, 0);
      plan_items(MODE_FLUSH, 0, 10, 1'b1, 0);
      // undersized geometry saturates, spare write bits are dropped
      plan_reg(REG_FRAME_WIDTH, 13'h1C04);
      plan_reg(REG_FRAME_HEIGHT, 13'd3);
      plan_reg(REG_VERT_SEL, {10'h2AA, KSEL_R5});
      plan_reg(REG_HORIZ_SEL, {10'h155, KSEL_E5});
      plan_reg(REG_MEAN_LEVEL, 13'h1ABC);
      plan_items(MODE_PIXEL, ANY_PIXEL, 25, 1'b0, 0);
      plan_items(MODE_FLUSH, 0, 10, 1'b0, 0);
      plan_reg(REG_UNUSED, 13'h1FFF);
      // oversized height, then shrink it mid-frame
      plan_reg(REG_FRAME_WIDTH, 13'd7);
      plan_reg(REG_FRAME_HEIGHT, 13'h1FFF);
      plan_reg(REG_VERT_SEL, {10'd0, KSEL_S5});
      plan_reg(REG_HORIZ_SEL, {10'd0, KSEL_W5});
      plan_reg(REG_MEAN_LEVEL, 13'd2048);
      plan_items(MODE_PIXEL, ANY_PIXEL, 21, 1'b0, 0);
      plan_reg(REG_FRAME_HEIGHT, 13'd6);
      plan_items(MODE_PIXEL, ANY_PIXEL, 21, 1'b0, 0);
      plan_items(MODE_FLUSH, 0, 14, 1'b0, 0);
      // oversized width saturates to the widest row
      plan_reg(REG_FRAME_WIDTH, 13'd1023);
      plan_reg(REG_FRAME_HEIGHT, 13'd5);
      plan_reg(REG_VERT_SEL, {10'd0, KSEL_W5});
      plan_reg(REG_HORIZ_SEL, {10'd0, KSEL_R5});
      plan_reg(REG_MEAN_LEVEL, 13'd4080);
      plan_items(MODE_PIXEL, ANY_PIXEL, 5 * MAX_WIDTH, 1'b0, 0);
      plan_items(MODE_FLUSH, 0, 2 * MAX_WIDTH, 1'b0, 0);

      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      gap_pct   = 10;
      stall_pct = 10;
      for (i = 0; i < plan.size(); i++) begin
         if (plan[i].kind == STEP_REG) begin
            write_reg(plan[i].idx, plan[i].value);
         end else begin
            for (n = 0; n < plan[i].reps; n++)
               send_item(plan[i].mode,
                         (plan[i].pixel == ANY_PIXEL) ? 8'($urandom_range(0, 255))
                                                      : 8'(plan[i].pixel),
                         plan[i].typed, plan[i].resp);
         end
      end

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(5, 16);
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(5, 8);
         spare = 13'($urandom());
         wide = 10'(w);
         write_reg(REG_FRAME_WIDTH, {spare[12:10], wide});
         write_reg(REG_FRAME_HEIGHT, 13'(h));
         if ($urandom_range(0, 3) != 0) begin
            sel = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                             : 3'($urandom_range(5, 7));
            write_reg(REG_VERT_SEL, {spare[9:0], sel});
         end
         if ($urandom_range(0, 3) != 0) begin
            sel = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                             : 3'($urandom_range(5, 7));
            write_reg(REG_HORIZ_SEL, {spare[12:3], sel});
         end
         if ($urandom_range(0, 3) != 0) begin
            mean = 12'($urandom());
            write_reg(REG_MEAN_LEVEL, {spare[0], mean});
         end

         if (random_items >= RANDOM_ITEMS * 4 / 5) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = $urandom_range(0, 3) * 15;
            stall_pct = $urandom_range(0, 3) * 15;
         end
         if (phase == 2) begin
            gap_pct = 0;
            hold_request = 1'b1;
         end

         for (row = 0; row < h; row++) begin
            if (phase == 5 && row == 3)
               wait_drained();
            for (colno = 0; colno < w; colno++) begin
               if ($urandom_range(0, 99) < 3)
                  send_item(MODE_FLUSH, 8'($urandom_range(0, 255)), 1'b0, 0);
               send_item(MODE_PIXEL, 8'($urandom_range(0, 255)), 1'b0, 0);
            end
         end
         for (colno = 0; colno < 2 * w; colno++) begin
            if ($urandom_range(0, 99) < 3)
               send_item(MODE_PIXEL, 8'($urandom_range(0, 255)), 1'b0, 0);
            send_item(MODE_FLUSH, 8'($urandom_range(0, 255)), 1'b0, 0);
         end
         random_items += w * h + 2 * w;
         phase++;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending.size() == 0)
         $display("laws_texture_filter_5x5_tb: done, clean");
      else
         $display("laws_texture_filter_5x5_tb: done, errors");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/ltf_pkg.sv
rtl/core/ltf_mask_sum.sv
rtl/core/ltf_rsp_fifo.sv
rtl/core/laws_texture_filter_5x5.sv
dv/laws_texture_filter_5x5_tb.sv
